// ===== rtl/core/pwb_pkg.sv =====
`timescale 1ns / 1ps
package pwb_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW = 5;

  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KI     = 3'd1;
  localparam logic [2:0] REG_KD     = 3'd2;
  localparam logic [2:0] REG_LIMIT  = 3'd3;
  localparam logic [2:0] REG_WINDOW = 3'd4;
  localparam logic [2:0] REG_INVLAM = 3'd5;
  localparam logic [2:0] REG_DIST   = 3'd6;
  localparam logic [2:0] REG_AW     = 3'd7;

  localparam logic OP_CALC  = 1'b0;
  localparam logic OP_TRACK = 1'b1;

  // multiplier operand select
  localparam logic [3:0] MS_KI   = 4'd0;
  localparam logic [3:0] MS_KP   = 4'd1;
  localparam logic [3:0] MS_KD   = 4'd2;
  localparam logic [3:0] MS_DC   = 4'd3;
  localparam logic [3:0] MS_FF   = 4'd4;
  localparam logic [3:0] MS_IL   = 4'd5;
  localparam logic [3:0] MS_CSP  = 4'd6;
  localparam logic [3:0] MS_CSD  = 4'd7;
  localparam logic [3:0] MS_CSX  = 4'd8;
  localparam logic [3:0] MS_CSI  = 4'd9;
  localparam logic [3:0] MS_AW   = 4'd10;

  typedef struct packed {
    logic [30:0] kp;
    logic [30:0] ki;
    logic [30:0] kd;
    logic [30:0] limit;
    logic [30:0] window;
    logic [30:0] invlam;
    logic [30:0] dcoef;
    logic [30:0] aw;
  } cfg_regs_t;

  typedef struct packed {
    logic        load;     // capture input, compute errors
    logic        mul_en;   // run multiplier with mul_sel
    logic [3:0]  mul_sel;
    logic        finish;   // form final result
    logic        op;
  } pwb_cmd_t;

  typedef struct packed {
    logic [31:0] position_error;
    logic [31:0] velocity_error;
    logic [31:0] p_term;
    logic [31:0] i_term;
    logic [31:0] d_term;
    logic [31:0] ff_term;
    logic [31:0] dist_term;
    logic [31:0] unsaturated_out;
    logic [31:0] applied_out;
    logic        frozen;
    logic        integral_clamped;
    logic        saturated;
  } pwb_out_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] ref_position;
    logic [31:0] est_position;
    logic [31:0] ref_velocity;
    logic [31:0] est_velocity;
    logic [31:0] ref_accel;
    logic [31:0] est_disturbance;
    logic [31:0] chassis_accel;
    logic [31:0] fb_scale;
    logic [31:0] ffw_scale;
    logic [31:0] applied_accel;
    logic [2:0]  gate_flags;
  } pwb_in_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'h7fff_ffff;
    if (v < -36'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // floor(product / 2^16) saturated
  function automatic logic [31:0] qsat(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = p[63:16];
    if (s > 48'sd2147483647) return 32'h7fff_ffff;
    if (s < -48'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

endpackage

// ===== rtl/core/pwb_stream_if.sv =====
`timescale 1ns / 1ps
interface pwb_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pid_with_backcalc_antiwindup.sv =====
`timescale 1ns / 1ps
// pid acceleration controller with back-calculation anti-windup, Q16.16
// in: valid/ready channel of items; opcode 0 calculates a new output,
//   opcode 1 tracks the applied (saturated) output and back-calculates
// out: one result beat per item, holding all terms and the three flags
// cfg: apb-style write/read port, eight 31-bit gains and limits at 4*i
// steps: a calculate passes the KI, KP, KD, DC, FF, IL, CSP, CSD, CSX,
//   CSI and FIN states, a track the AW and FIN states; one shared 32x32
//   multiplier serves every step but AW, which has its own product
// flow: one item at a time; the next item is accepted once the previous
//   one is finished, while its result may still wait in the output
//   register
// reset: synchronous active low; integrator, stored result and flags
//   clear, registers go to zero except inv_lambda = 1.0
// stall: out_valid holds with a stable beat until out_ready; a finished
//   item waits in its last step if the previous beat was not yet taken
module pid_with_backcalc_antiwindup import pwb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  pwb_stream_if.sink         in_if,
  pwb_stream_if.source       out_if,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [AddrW-1:0]   cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  cfg_regs_t cfg;
  pwb_cmd_t  cmd;
  logic      run_int;
  pwb_in_t   din;

  assign din = in_if.payload;

  pwb_cfg_regs u_regs (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg(cfg)
  );

  // sequencer: at most one multiplier step per state, none in idle or finish
  pwb_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_if.valid), .in_op(din.opcode), .run_int(run_int),
    .in_ready(in_if.ready), .out_valid(out_if.valid), .out_ready(out_if.ready),
    .cmd(cmd)
  );

  // shared multiplier, integrator and stored result
  pwb_datapath u_dp (
    .clk, .rst_n, .cfg(cfg), .din(din), .cmd(cmd),
    .run_int(run_int), .res(out_if.payload)
  );
endmodule

// ===== rtl/core/pwb_ctrl.sv =====
`timescale 1ns / 1ps
module pwb_ctrl import pwb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  input  logic     run_int,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pwb_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KI   = 4'd1;
  localparam logic [3:0] S_KP   = 4'd2;
  localparam logic [3:0] S_KD   = 4'd3;
  localparam logic [3:0] S_DC   = 4'd4;
  localparam logic [3:0] S_FF   = 4'd5;
  localparam logic [3:0] S_IL   = 4'd6;
  localparam logic [3:0] S_CSP  = 4'd7;
  localparam logic [3:0] S_CSD  = 4'd8;
  localparam logic [3:0] S_CSX  = 4'd9;
  localparam logic [3:0] S_CSI  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_AW   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       op_r, op_nxt;
  logic       ov_r, ov_nxt;

  // a waiting result only holds the item in its last step
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    ov_nxt = ov_r && !out_ready;
    cmd = '0;
    cmd.op = op_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          op_nxt = in_op;
          state_nxt = (in_op == OP_TRACK) ? S_AW : S_KI;
        end
      end
      S_KI: begin
        cmd.mul_en = run_int;
        cmd.mul_sel = MS_KI;
        state_nxt = S_KP;
      end
      S_KP:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_KP;  state_nxt = S_KD;  end
      S_KD:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_KD;  state_nxt = S_DC;  end
      S_DC:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_DC;  state_nxt = S_FF;  end
      S_FF:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_FF;  state_nxt = S_IL;  end
      S_IL:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_IL;  state_nxt = S_CSP; end
      S_CSP: begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_CSP; state_nxt = S_CSD; end
      S_CSD: begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_CSD; state_nxt = S_CSX; end
      S_CSX: begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_CSX; state_nxt = S_CSI; end
      S_CSI: begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_CSI; state_nxt = S_FIN; end
      S_AW:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_AW;  state_nxt = S_FIN; end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.finish = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= OP_CALC;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

// ===== rtl/core/pwb_datapath.sv =====
`timescale 1ns / 1ps
module pwb_datapath import pwb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  pwb_in_t   din,
  input  pwb_cmd_t  cmd,
  output logic      run_int,
  output pwb_out_t  res
);
  // captured operands
  logic [31:0] pe_r, ve_r, ra_r, ed_r, ca_r, cs_r, fs_r, app_r;
  logic [2:0]  gates_r;
  logic [31:0] kpe_r, kde_r, dce_r, ffa_r, ilr_r;
  logic [31:0] pt_r, dt_r, xt_r, it_r;
  logic signed [32:0] diff_r;
  logic        run_r;
  logic        clk_hit_r;
  logic [31:0] integ_r;
  pwb_out_t    res_r;

  logic signed [32:0] pe_w, ve_w;
  logic [31:0] pe_s, ve_s, ape;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [49:0] ival;
  logic signed [31:0] lim;
  logic [31:0] iclamp;
  logic        ihit;

  assign pe_w = $signed({din.ref_position[31], din.ref_position})
              - $signed({din.est_position[31], din.est_position});
  assign ve_w = $signed({din.ref_velocity[31], din.ref_velocity})
              - $signed({din.est_velocity[31], din.est_velocity});
  assign pe_s = sat32(36'(pe_w));
  assign ve_s = sat32(36'(ve_w));
  assign ape  = pe_s[31] ? (32'd0 - pe_s) : pe_s;

  assign run_int = run_r;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MS_KI:  begin ma = $signed({1'b0, cfg.ki});     mb = pe_r;  end
      MS_KP:  begin ma = $signed({1'b0, cfg.kp});     mb = pe_r;  end
      MS_KD:  begin ma = $signed({1'b0, cfg.kd});     mb = ve_r;  end
      MS_DC:  begin ma = $signed({1'b0, cfg.dcoef});  mb = ed_r;  end
      MS_FF:  begin ma = fs_r;                         mb = ca_r;  end
      MS_IL:  begin ma = $signed({1'b0, cfg.invlam}); mb = ra_r;  end
      MS_CSP: begin ma = cs_r;                         mb = kpe_r; end
      MS_CSD: begin ma = cs_r;                         mb = kde_r; end
      MS_CSX: begin ma = cs_r;                         mb = dce_r; end
      MS_CSI: begin ma = cs_r;                         mb = integ_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // aw product uses the 33-bit difference: kept separate
  logic signed [64:0] awprod;
  assign awprod = $signed({2'b00, cfg.aw}) * diff_r;
  assign prod = ma * mb;

  // exact sum before the clamp; the back-calculated step reaches 49 bits
  always_comb begin
    if (cmd.mul_sel == MS_AW)
      ival = $signed({{18{integ_r[31]}}, integ_r})
           + $signed({awprod[64], awprod[64:16]});
    else
      ival = $signed({{18{integ_r[31]}}, integ_r})
           + $signed({{18{prod[63]}}, qsat(prod)});
    lim = $signed({1'b0, cfg.limit});
    if (ival > 50'(lim)) begin
      iclamp = lim; ihit = 1'b1;
    end else if (ival < -50'(lim)) begin
      iclamp = -lim; ihit = 1'b1;
    end else begin
      iclamp = ival[31:0]; ihit = 1'b0;
    end
  end

  logic signed [35:0] sum5;
  logic signed [33:0] ffsum, negx;
  assign ffsum = $signed({{2{ffa_r[31]}}, ffa_r}) + $signed({{2{ilr_r[31]}}, ilr_r});
  assign negx = -$signed({{2{xt_r[31]}}, xt_r});
  assign sum5 = 36'(signed'(pt_r)) + 36'(signed'(it_r)) + 36'(signed'(dt_r))
              + 36'(signed'(sat32(36'(ffsum)))) + 36'(signed'(sat32(36'(negx))));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pe_r <= pe_s; ve_r <= ve_s;
      ra_r <= din.ref_accel; ed_r <= din.est_disturbance;
      ca_r <= din.chassis_accel; cs_r <= din.fb_scale;
      fs_r <= din.ffw_scale; app_r <= din.applied_accel;
      gates_r <= din.gate_flags;
      diff_r <= $signed({din.applied_accel[31], din.applied_accel})
              - $signed({res_r.unsaturated_out[31], res_r.unsaturated_out});
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MS_KP:  kpe_r <= qsat(prod);
        MS_KD:  kde_r <= qsat(prod);
        MS_DC:  dce_r <= qsat(prod);
        MS_FF:  ffa_r <= qsat(prod);
        MS_IL:  ilr_r <= qsat(prod);
        MS_CSP: pt_r  <= qsat(prod);
        MS_CSD: dt_r  <= qsat(prod);
        MS_CSX: xt_r  <= qsat(prod);
        MS_CSI: it_r  <= qsat(prod);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      res_r <= '0;
      run_r <= 1'b0;
      clk_hit_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        run_r <= din.gate_flags[0] && (ape <= {1'b0, cfg.window});
        clk_hit_r <= 1'b0;
      end
      if (cmd.mul_en && cmd.mul_sel == MS_KI) begin
        integ_r <= iclamp;
        clk_hit_r <= ihit;
      end
      if (cmd.mul_en && cmd.mul_sel == MS_AW) begin
        if ((diff_r != 0 || gates_r[1]) && gates_r[2]) begin
          integ_r <= iclamp;
          clk_hit_r <= ihit;
        end
      end
      if (cmd.finish) begin
        if (cmd.op == OP_CALC) begin
          res_r.position_error <= pe_r;
          res_r.velocity_error <= ve_r;
          res_r.p_term <= pt_r;
          res_r.i_term <= it_r;
          res_r.d_term <= dt_r;
          res_r.ff_term <= sat32(36'(ffsum));
          res_r.dist_term <= sat32(36'(negx));
          res_r.unsaturated_out <= sat32(sum5);
          res_r.applied_out <= sat32(sum5);
          res_r.frozen <= !run_r;
          res_r.integral_clamped <= clk_hit_r;
          res_r.saturated <= 1'b0;
        end else begin
          res_r.applied_out <= app_r;
          res_r.saturated <= (diff_r != 0);
          res_r.frozen <= res_r.frozen | gates_r[1];
          res_r.integral_clamped <= res_r.integral_clamped | clk_hit_r;
        end
      end
    end
  end

  assign res = res_r;
endmodule

// ===== rtl/core/pwb_cfg_regs.sv =====
`timescale 1ns / 1ps
module pwb_cfg_regs import pwb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_regs_t        cfg
);
  cfg_regs_t regs_r;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = regs_r;

  always_comb begin
    case (idx)
      REG_KP:     prdata = {1'b0, regs_r.kp};
      REG_KI:     prdata = {1'b0, regs_r.ki};
      REG_KD:     prdata = {1'b0, regs_r.kd};
      REG_LIMIT:  prdata = {1'b0, regs_r.limit};
      REG_WINDOW: prdata = {1'b0, regs_r.window};
      REG_INVLAM: prdata = {1'b0, regs_r.invlam};
      REG_DIST:   prdata = {1'b0, regs_r.dcoef};
      REG_AW:     prdata = {1'b0, regs_r.aw};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // all zero but inv_lambda = 1.0
      regs_r <= {{5{31'd0}}, 31'd65536, {2{31'd0}}};
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        REG_KP:     regs_r.kp <= pwdata[30:0];
        REG_KI:     regs_r.ki <= pwdata[30:0];
        REG_KD:     regs_r.kd <= pwdata[30:0];
        REG_LIMIT:  regs_r.limit <= pwdata[30:0];
        REG_WINDOW: regs_r.window <= pwdata[30:0];
        REG_INVLAM: regs_r.invlam <= pwdata[30:0];
        REG_DIST:   regs_r.dcoef <= pwdata[30:0];
        REG_AW:     regs_r.aw <= pwdata[30:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import pwb_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam longint SMax = 64'sd2147483647;
  localparam longint SMin = -64'sd2147483648;

  // saturation helpers for the controller prediction
  function automatic longint clip32(longint v);
    if (v > SMax) return SMax;
    if (v < SMin) return SMin;
    return v;
  endfunction

  // q16.16 product, floor rounding, saturated
  function automatic longint qprod(longint a, longint b);
    return clip32((a * b) >>> 16);
  endfunction

  // ---------------------------------------------------------------------------
  // controller ledger: predicts each result beat and checks it against the dut
  // ---------------------------------------------------------------------------
  class pid_ledger;
    longint gain[NumRegs];
    longint integ;
    longint held[9];
    bit held_frozen, held_clamped, held_sat;
    pwb_out_t awaited[$];
    int unsigned errors;
    int unsigned beats_in, beats_out, n_calc, n_track, n_sat, n_clamp;

    function new();
      foreach (gain[i]) gain[i] = 0;
      gain[REG_INVLAM] = 65536;
      integ = 0;
      foreach (held[i]) held[i] = 0;
      {held_frozen, held_clamped, held_sat} = '0;
      errors = 0;
    endfunction

    function void set_gain(logic [2:0] idx, logic [31:0] val);
      gain[idx] = longint'(val[30:0]);
    endfunction

    function longint last_unsat();
      return held[7];
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // clamp to +-limit, returns 1 when the limit bit
    function bit load_integ(longint v);
      longint c;
      c = v;
      if (c > gain[REG_LIMIT]) c = gain[REG_LIMIT];
      if (c < -gain[REG_LIMIT]) c = -gain[REG_LIMIT];
      integ = c;
      return c != v;
    endfunction

    function void note_input(pwb_in_t it);
      longint pe, ve, cs, diff, corr;
      bit run, clamped, force_frz;
      pwb_out_t r;
      beats_in++;
      if (it.opcode == OP_CALC) begin
        n_calc++;
        pe = clip32(longint'($signed(it.ref_position)) - longint'($signed(it.est_position)));
        ve = clip32(longint'($signed(it.ref_velocity)) - longint'($signed(it.est_velocity)));
        cs = longint'($signed(it.fb_scale));
        run = it.gate_flags[0] && ((pe < 0 ? -pe : pe) <= gain[REG_WINDOW]);
        clamped = 0;
        if (run) clamped = load_integ(integ + qprod(gain[REG_KI], pe));
        held[0] = pe;
        held[1] = ve;
        held[2] = qprod(cs, qprod(gain[REG_KP], pe));
        held[3] = qprod(cs, integ);
        held[4] = qprod(cs, qprod(gain[REG_KD], ve));
        held[5] = clip32(qprod($signed(it.ffw_scale), $signed(it.chassis_accel))
                       + qprod(gain[REG_INVLAM], $signed(it.ref_accel)));
        held[6] = clip32(-qprod(cs, qprod(gain[REG_DIST], $signed(it.est_disturbance))));
        held[7] = clip32(held[2] + held[3] + held[4] + held[5] + held[6]);
        held[8] = held[7];
        held_frozen = !run;
        held_clamped = clamped;
        held_sat = 0;
      end else begin
        n_track++;
        diff = longint'($signed(it.applied_accel)) - held[7];
        force_frz = it.gate_flags[1];
        held[8] = longint'($signed(it.applied_accel));
        held_sat = (diff != 0);
        if (force_frz) held_frozen = 1;
        // back-calculation: product is not saturated here
        if ((held_sat || force_frz) && it.gate_flags[2]) begin
          corr = (gain[REG_AW] * diff) >>> 16;
          if (load_integ(integ + corr)) held_clamped = 1;
        end
      end
      if (held_sat) n_sat++;
      if (held_clamped) n_clamp++;
      r.position_error   = held[0][31:0];
      r.velocity_error   = held[1][31:0];
      r.p_term           = held[2][31:0];
      r.i_term           = held[3][31:0];
      r.d_term           = held[4][31:0];
      r.ff_term          = held[5][31:0];
      r.dist_term        = held[6][31:0];
      r.unsaturated_out  = held[7][31:0];
      r.applied_out      = held[8][31:0];
      r.frozen           = held_frozen;
      r.integral_clamped = held_clamped;
      r.saturated        = held_sat;
      awaited.push_back(r);
    endfunction

    function void field(string nm, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] beat %0d %s: want %h got %h", $time, beats_out, nm, want, got);
      end
    endfunction

    function void check_result(pwb_out_t got);
      pwb_out_t w;
      beats_out++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("[%0t] result beat with nothing pending", $time);
        return;
      end
      w = awaited.pop_front();
      field("position_error", w.position_error, got.position_error);
      field("velocity_error", w.velocity_error, got.velocity_error);
      field("p_term", w.p_term, got.p_term);
      field("i_term", w.i_term, got.i_term);
      field("d_term", w.d_term, got.d_term);
      field("ff_term", w.ff_term, got.ff_term);
      field("dist_term", w.dist_term, got.dist_term);
      field("unsaturated_out", w.unsaturated_out, got.unsaturated_out);
      field("applied_out", w.applied_out, got.applied_out);
      field("frozen", w.frozen, got.frozen);
      field("integral_clamped", w.integral_clamped, got.integral_clamped);
      field("saturated", w.saturated, got.saturated);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  pwb_stream_if #(.payload_t(pwb_in_t))  in_ch ();
  pwb_stream_if #(.payload_t(pwb_out_t)) out_ch ();

  pid_with_backcalc_antiwindup dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pid_ledger ledger = new();

  // idle mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
  int unsigned idle_mode;
  int unsigned cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("watchdog expired after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit sender_gap();
    return (idle_mode == 1) ? roll(51) : (idle_mode == 3) ? roll(34) : 1'b0;
  endfunction

  // result side: check each accepted beat, then pick next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) ledger.check_result(out_ch.payload);
      if (idle_mode == 2) out_ch.ready <= !roll(51);
      else if (idle_mode == 3) out_ch.ready <= !roll(34);
      else out_ch.ready <= 1'b1;
    end
  end

  // drive one beat, optional gaps first; returns at the accepting edge
  task automatic send_item(pwb_in_t it);
    while (sender_gap()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_input(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    // calc latency headroom before touching registers
    repeat (16) @(posedge clk);
  endtask

  // apb write: setup then access, register lands on the access edge
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= AddrW'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    ledger.set_gain(idx, val);
    @(posedge clk);
  endtask

  // register set kinds: 0 realistic, 1 all max, 2 all zero, 3 fully random
  task automatic load_gains(int unsigned kind);
    logic [31:0] v [NumRegs];
    for (int i = 0; i < NumRegs; i++) begin
      case (kind)
        0: v[i] = $urandom_range(0, 32'h0003_0000);
        1: v[i] = 32'h7fff_ffff;
        2: v[i] = 32'h0;
        default: v[i] = $urandom;
      endcase
    end
    if (kind == 0) begin
      v[REG_LIMIT]  = $urandom_range(0, 32'h0020_0000);
      v[REG_WINDOW] = $urandom_range(0, 32'h0008_0000);
      v[REG_INVLAM] = $urandom_range(32'h0000_8000, 32'h0002_0000);
    end
    // upper bit set on purpose; the register drops it
    if (kind == 3) v[REG_KP][31] = 1'b1;
    for (int i = 0; i < NumRegs; i++) write_reg(i[2:0], v[i]);
  endtask

  // q16.16 operand mix: extremes, zero, small magnitudes, anything
  function automatic logic [31:0] pick_q();
    int unsigned m;
    m = $urandom_range(0, 9);
    case (m)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4, 5: return roll(50) ? $urandom_range(0, 32'h0004_0000)
                               : -$urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic pwb_in_t make_calc(bit tame);
    pwb_in_t it;
    it.opcode            = OP_CALC;
    it.ref_position      = pick_q();
    it.est_position      = pick_q();
    it.ref_velocity      = pick_q();
    it.est_velocity      = pick_q();
    it.ref_accel         = pick_q();
    it.est_disturbance   = pick_q();
    it.chassis_accel     = pick_q();
    it.fb_scale          = pick_q();
    it.ffw_scale         = pick_q();
    it.applied_accel     = $urandom;
    it.gate_flags        = $urandom_range(0, 7);
    if (tame) begin
      // keep position error near the window so the integrator really runs
      it.est_position     = it.ref_position - ($urandom_range(0, 32'h000a_0000) - 32'h0005_0000);
      it.fb_scale         = $urandom_range(0, 32'h0002_0000);
      it.gate_flags[0]    = roll(80);
    end
    return it;
  endfunction

  // track beat: applied equals the sum, a perturbed copy of it, or anything
  function automatic pwb_in_t make_track();
    pwb_in_t it;
    longint u;
    it = make_calc(1'b0);
    it.opcode = OP_TRACK;
    u = ledger.last_unsat();
    case ($urandom_range(0, 3))
      0: it.applied_accel = u[31:0];
      1: it.applied_accel = u[31:0] + ($urandom_range(0, 32'h0001_0000) - 32'h0000_8000);
      2: it.applied_accel = (u > 0) ? u[31:0] >> 1 : u[31:0] + 32'h0001_0000;
      default: it.applied_accel = pick_q();
    endcase
    return it;
  endfunction

  task automatic run_directed();
    pwb_in_t it;
    // track before any calculate: works on the all-zero stored result
    it = make_track();
    it.applied_accel = 32'h0;
    it.gate_flags = 3'b111;
    send_item(it);
    it.applied_accel = 32'h0005_0000;
    send_item(it);
    drain();
    load_gains(0);
    // zero-limit integrator hold
    write_reg(REG_LIMIT, 32'h0);
    it = make_calc(1'b1);
    it.gate_flags = 3'b001;
    send_item(it);
    drain();
    write_reg(REG_LIMIT, 32'h0010_0000);
    // error extremes, both signs of overflow
    it = make_calc(1'b0);
    it.ref_position = 32'h7fff_ffff; it.est_position = 32'h8000_0000;
    it.ref_velocity = 32'h8000_0000; it.est_velocity = 32'h7fff_ffff;
    send_item(it);
    it.ref_position = 32'h8000_0000; it.est_position = 32'h7fff_ffff;
    it.ref_velocity = 32'h7fff_ffff; it.est_velocity = 32'h8000_0000;
    send_item(it);
    // all operands at max, then min
    it = make_calc(1'b0);
    {it.ref_accel, it.est_disturbance, it.chassis_accel} = {3{32'h7fff_ffff}};
    {it.fb_scale, it.ffw_scale} = {2{32'h7fff_ffff}};
    send_item(it);
    {it.ref_accel, it.est_disturbance, it.chassis_accel} = {3{32'h8000_0000}};
    {it.fb_scale, it.ffw_scale} = {2{32'h8000_0000}};
    send_item(it);
    // position error right at the window edge and one step past it
    it = make_calc(1'b1);
    it.gate_flags = 3'b001;
    it.ref_position = it.est_position + ledger.gain[REG_WINDOW][31:0];
    send_item(it);
    it.ref_position = it.est_position - ledger.gain[REG_WINDOW][31:0] - 1;
    send_item(it);
    // integrator disabled, then tracks: match, mismatch, forced freeze
    it = make_calc(1'b1);
    it.gate_flags = 3'b000;
    send_item(it);
    it = make_track(); it.applied_accel = 32'(ledger.last_unsat()); it.gate_flags = 3'b100;
    send_item(it);
    it.gate_flags = 3'b110;
    send_item(it);
    it = make_track(); it.applied_accel = 32'(ledger.last_unsat() + 1);
    it.gate_flags = 3'b100;
    send_item(it);
    it.applied_accel = 32'h8000_0000; it.gate_flags = 3'b011;
    send_item(it);
    it.applied_accel = 32'h7fff_ffff; it.gate_flags = 3'b111;
    send_item(it);
    drain();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    idle_mode     = 0;
    cycles        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // eight phases of about a hundred beats each; idling styles rotate and the
    // register set is all max in phase 1, zero in 5, random in 6, else realistic
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 4;
      load_gains((ph == 1) ? 1 : (ph == 5) ? 2 : (ph == 6) ? 3 : 0);
      for (int n = 0; n < 100; n++) begin
        // mostly calc/track pairs with random content, some noise
        if (roll(75)) begin
          send_item(make_calc(roll(70)));
          send_item(make_track());
          n++;
        end else begin
          send_item(roll(50) ? make_calc(1'b0) : make_track());
        end
        // sender holds off until the block has emptied out
        if (ph == 3 && n == 50) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (ledger.pending() != 0) @(posedge clk);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d beats in (%0d calc, %0d track), %0d results checked",
             ledger.beats_in, ledger.n_calc, ledger.n_track, ledger.beats_out);
    $display("saturated results %0d, clamped results %0d, across 8 register sets",
             ledger.n_sat, ledger.n_clamp);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", ledger.errors, ledger.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
